[rtl/hcd_pkg.sv]
`timescale 1ns / 1ps
package hcd_pkg;

   localparam int LEN_BITS = 24;
   localparam int COUNT_BITS = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam int RSP_DATA_BITS = 40;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_DATA    = 3'd1,
      PH_DATA_CR = 3'd2,
      PH_DATA_LF = 3'd3,
      PH_DONE    = 3'd4,
      PH_FAULT   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      FLT_NONE         = 3'd0,
      FLT_UNTERMINATED = 3'd1,
      FLT_EMPTY_LINE   = 3'd2,
      FLT_NO_HEX       = 3'd3,
      FLT_SHORT_DATA   = 3'd4,
      FLT_NO_CRLF      = 3'd5,
      FLT_SIZE_WIDE    = 3'd6
   } fault_type;

   typedef struct packed {
      phase_type             phase;
      logic                  cr_pending;
      logic                  line_has_content;
      logic                  hex_stopped;
      logic                  hex_seen;
      logic                  size_overflow;
      logic [LEN_BITS-1:0]   chunk_remaining;
      logic [COUNT_BITS-1:0] payload_count;
      fault_type             sticky_fault;
   } parse_state_type;

   typedef struct packed {
      logic                  payload_valid;
      logic [7:0]            payload_byte;
      logic                  body_end;
      logic                  decode_ok;
      fault_type             fault_code;
      logic [COUNT_BITS-1:0] decoded_length;
   } parse_result_type;

   localparam parse_state_type STATE_RESET = '{
      phase: PH_SIZE, cr_pending: 1'b0, line_has_content: 1'b0, hex_stopped: 1'b0,
      hex_seen: 1'b0, size_overflow: 1'b0, chunk_remaining: '0, payload_count: '0,
      sticky_fault: FLT_NONE};

   // bit 4 set when the byte is a hex digit, low nibble holds its value
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      return r;
   endfunction

endpackage

[rtl/hcd_parse.sv]
`timescale 1ns / 1ps
module hcd_parse import hcd_pkg::*; (
   input  parse_state_type  cur_state,
   input  logic [7:0]       body_byte,
   input  logic             final_byte,
   output parse_state_type  next_state,
   output parse_result_type result
);

   parse_state_type s;
   logic [4:0]      hv;
   logic            closed_after_data;
   fault_type       code;

   assign hv = hex_value(body_byte);

   always_comb begin
      s = cur_state;
      closed_after_data = 1'b0;
      result = '0;
      code = FLT_NONE;
      case (cur_state.phase)
         PH_SIZE: begin
            if (cur_state.cr_pending && body_byte == CH_LF) begin
               // line end checks
               if (!cur_state.line_has_content) begin
                  s = STATE_RESET;
                  s.payload_count = cur_state.payload_count;
                  s.sticky_fault = FLT_EMPTY_LINE;
                  s.phase = PH_FAULT;
               end else if (!cur_state.hex_seen) begin
                  s = STATE_RESET;
                  s.payload_count = cur_state.payload_count;
                  s.sticky_fault = FLT_NO_HEX;
                  s.phase = PH_FAULT;
               end else if (cur_state.size_overflow) begin
                  s = STATE_RESET;
                  s.payload_count = cur_state.payload_count;
                  s.sticky_fault = FLT_SIZE_WIDE;
                  s.phase = PH_FAULT;
               end else begin
                  s.phase = (cur_state.chunk_remaining == '0) ? PH_DONE : PH_DATA;
                  s.cr_pending = 1'b0;
                  s.line_has_content = 1'b0;
                  s.hex_stopped = 1'b0;
                  s.hex_seen = 1'b0;
                  s.size_overflow = 1'b0;
               end
            end else begin
               // a lone cr is non-hex line content
               if (cur_state.cr_pending) begin
                  s.line_has_content = 1'b1;
                  s.hex_stopped = 1'b1;
                  s.cr_pending = 1'b0;
               end
               if (body_byte == CH_CR) begin
                  s.cr_pending = 1'b1;
               end else begin
                  s.line_has_content = 1'b1;
                  if (s.hex_stopped || !hv[4]) begin
                     s.hex_stopped = 1'b1;
                  end else begin
                     s.hex_seen = 1'b1;
                     if (!s.size_overflow) begin
                        if (s.chunk_remaining[LEN_BITS-1 -: 4] != 4'd0) begin
                           s.size_overflow = 1'b1;
                        end else begin
                           s.chunk_remaining = {s.chunk_remaining[LEN_BITS-5:0], hv[3:0]};
                        end
                     end
                  end
               end
            end
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte = body_byte;
            if (cur_state.payload_count != COUNT_MAX) begin
               s.payload_count = cur_state.payload_count + 1'b1;
            end
            if (cur_state.chunk_remaining != '0) begin
               s.chunk_remaining = cur_state.chunk_remaining - 1'b1;
            end
            if (s.chunk_remaining == '0) s.phase = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (body_byte == CH_CR) begin
               s.phase = PH_DATA_LF;
            end else begin
               s.sticky_fault = FLT_NO_CRLF;
               s.phase = PH_FAULT;
            end
         end
         PH_DATA_LF: begin
            if (body_byte == CH_LF) begin
               s = STATE_RESET;
               s.payload_count = cur_state.payload_count;
               s.sticky_fault = cur_state.sticky_fault;
               closed_after_data = 1'b1;
            end else begin
               s.sticky_fault = FLT_NO_CRLF;
               s.phase = PH_FAULT;
            end
         end
         PH_DONE, PH_FAULT: begin
         end
         default: begin
            s = STATE_RESET;
            s.payload_count = cur_state.payload_count;
            s.sticky_fault = cur_state.sticky_fault;
         end
      endcase

      if (final_byte) begin
         if (s.sticky_fault != FLT_NONE) code = s.sticky_fault;
         else if (s.phase == PH_DONE || closed_after_data) code = FLT_NONE;
         else if (s.phase == PH_SIZE) code = FLT_UNTERMINATED;
         else if (s.phase == PH_DATA) code = FLT_SHORT_DATA;
         else code = FLT_NO_CRLF;
      end

      result.body_end = final_byte;
      result.decode_ok = final_byte && (code == FLT_NONE);
      result.fault_code = code;
      result.decoded_length = s.payload_count;

      next_state = final_byte ? STATE_RESET : s;
   end

endmodule

[rtl/http_chunked_decoder.sv]
`timescale 1ns / 1ps
// channel | dir | tdata                              | tuser         | tlast
// req     | in  | body_byte[7:0]                     | -             | final_byte
// rsp     | out | payload_byte, ok, fault, length    | payload_valid | body_end
//
// one byte per cycle sustained while rsp is not stalled; an accepted item waits
// in the input register; as it leaves, the parser result is loaded into the
// result register, which drives rsp. the parser state
// updates as the item leaves the input register. reset clears the parser and
// both valid flags. a stalled rsp holds its item and the input register fills
// before req_tready drops.
module http_chunked_decoder import hcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // body_byte[7:0]
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // payload_byte[7:0], decode_ok[8], fault_code[11:9], decoded_length[35:12], zero[39:36]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser,   // payload_valid[0]
   output logic                     rsp_tlast
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   parse_state_type  state_ff, state_in;
   logic             out_valid_ff, out_valid_in;
   parse_result_type out_res_ff;
   parse_result_type res;
   logic             advance;
   logic             out_free;

   hcd_parse u_parse (
      .cur_state  (state_ff),
      .body_byte  (in_byte_ff),
      .final_byte (in_last_ff),
      .next_state (state_in),
      .result     (res)
   );

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) out_res_ff <= res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_res_ff.payload_valid;
   assign rsp_tlast = out_res_ff.body_end;
   assign rsp_tdata = {4'd0, out_res_ff.decoded_length, out_res_ff.fault_code,
                       out_res_ff.decode_ok, out_res_ff.payload_byte};

endmodule
